// File: rtl/core/sle_pkg.sv
// Shared types and constants for the sequential list engine.
package sle_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic exec;       // run a non-locate command
        logic scan_step;  // compare one entry for locate
    } ctl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_locate;
        logic scan_end;
    } status_t;

endpackage

// File: rtl/core/sle_ctrl.sv
// Controller state machine for the sequential list engine.
module sle_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sle_pkg::status_t status,
    output sle_pkg::ctl_t    ctl,
    output logic             busy,
    output logic             done
);
    import sle_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_locate)
                begin
                    ctl.scan_step = 1'b1;
                    if (status.scan_end)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    ctl.exec   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/core/sle_datapath.sv
// Datapath of the sequential list engine: element cells, length and result registers.
module sle_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sle_pkg::CMD_W-1:0]         cmd,
    input  logic [sle_pkg::POS_W-1:0]         position,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    input  sle_pkg::ctl_t                     ctl,
    output sle_pkg::status_t                  status,
    output logic                              ok,
    output logic signed [sle_pkg::DATA_W-1:0] read_value,
    output logic [sle_pkg::LEN_W-1:0]         found_position,
    output logic [sle_pkg::LEN_W-1:0]         list_length,
    output logic                              is_empty
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] key_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     scan_reg;
    logic [CW-1:0]     scan_next;
    logic              ok_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [LEN_W-1:0]  found_reg;

    logic [DATA_W-1:0] cell_q [CAPACITY];

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     pm1_x;
    logic [XW-1:0]     found_x;
    logic [XW-1:0]     len_x;
    logic              pos_nz;
    logic              ins_ok;
    logic              acc_ok;
    logic [AW-1:0]     rd_idx;
    logic [DATA_W-1:0] cell_rd;
    logic              do_ins;
    logic              do_del;
    logic              do_upd;
    logic              do_get;
    logic              success;
    logic              scan_in;
    logic              hit;

    assign pos_x   = XW'(pos_reg);
    assign cnt_x   = XW'(count_reg);
    assign pm1_x   = pos_x - XW'(1);
    assign pos_nz  = (pos_reg != '0);
    assign ins_ok  = pos_nz && (pm1_x <= cnt_x) && (count_reg != CW'(CAPACITY));
    assign acc_ok  = pos_nz && (pos_x <= cnt_x);
    assign rd_idx  = (cmd_reg == CMD_LOCATE) ? scan_reg[AW-1:0] : pm1_x[AW-1:0];
    assign cell_rd = cell_q[rd_idx];

    always_comb
    begin
        do_ins = 1'b0;
        do_del = 1'b0;
        do_upd = 1'b0;
        do_get = 1'b0;
        unique case (cmd_reg)
            CMD_INSERT: do_ins = ins_ok;
            CMD_DELETE: do_del = acc_ok;
            CMD_UPDATE: do_upd = acc_ok;
            CMD_GET:    do_get = acc_ok;
            default:    ;
        endcase
    end

    assign success = do_ins || do_del || do_upd || do_get;

    // Locate walks the cells one per cycle through the shared read port.
    assign scan_in          = (XW'(scan_reg) < cnt_x);
    assign hit              = scan_in && (cell_rd == key_reg);
    assign status.scan_end  = !scan_in || hit;
    assign status.is_locate = (cmd_reg == CMD_LOCATE);
    assign found_x          = XW'(scan_reg) + XW'(1);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [XW-1:0] IX  = XW'(i);
        localparam logic [XW-1:0] IX1 = XW'(i + 1);

        logic [DATA_W-1:0] data_reg;
        logic [DATA_W-1:0] data_next;
        logic [DATA_W-1:0] below;
        logic [DATA_W-1:0] above;

        if (i == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_lower
            assign below = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign above = '0;
        end
        else
        begin : g_upper
            assign above = cell_q[i+1];
        end

        // Insert shifts up from the slot, delete shifts down into it.
        always_comb
        begin
            data_next = data_reg;
            if (ctl.exec)
            begin
                if (do_ins)
                begin
                    if (IX == pm1_x)
                    begin
                        data_next = key_reg;
                    end
                    else if ((IX > pm1_x) && (IX <= cnt_x))
                    begin
                        data_next = below;
                    end
                end
                else if (do_del)
                begin
                    if ((IX >= pm1_x) && (IX1 < cnt_x))
                    begin
                        data_next = above;
                    end
                end
                else if (do_upd && (IX == pm1_x))
                begin
                    data_next = key_reg;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            data_reg <= data_next;
        end

        assign cell_q[i] = data_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.exec && do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.exec && do_del)
        begin
            count_next = count_reg - CW'(1);
        end

        scan_next = scan_reg;
        if (ctl.load)
        begin
            scan_next = '0;
        end
        else if (ctl.scan_step && !status.scan_end)
        begin
            scan_next = scan_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
            cmd_reg   <= CMD_INSERT;
        end
        else
        begin
            count_reg <= count_next;
            scan_reg  <= scan_next;
            if (ctl.load)
            begin
                cmd_reg <= cmd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg <= position;
            key_reg <= value;
        end
        if (ctl.exec)
        begin
            ok_reg    <= success;
            rd_reg    <= (do_del || do_get) ? cell_rd : '0;
            found_reg <= '0;
        end
        else if (ctl.scan_step && status.scan_end)
        begin
            ok_reg    <= 1'b1;
            rd_reg    <= '0;
            found_reg <= hit ? found_x[LEN_W-1:0] : '0;
        end
    end

    assign len_x          = XW'(count_reg);
    assign ok             = ok_reg;
    assign read_value     = rd_reg;
    assign found_position = found_reg;
    assign list_length    = len_x[LEN_W-1:0];
    assign is_empty       = (count_reg == '0);

endmodule

// File: rtl/core/sequential_list_engine_top.sv
// Top level of the sequential list engine: ordered list of signed 32-bit values.
//
// A request is taken at a rising edge with start high and busy low; its result
// is shown for exactly one cycle while done is high, and the receiver cannot
// stall it. Insert, delete, update and get capture the request, then execute it
// in a step in which the affected cells shift or load in parallel. Locate compares
// one entry per cycle through the single read port of the cell array and stops at
// the first match or after the last entry. A new request may be accepted in the
// same cycle in which done shows the previous result. Every result carries the
// length after the command and an empty flag; a failed command leaves the list
// unchanged and returns zero for read_value and found_position.
module sequential_list_engine_top
#(
    parameter int CAPACITY = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sle_pkg::CMD_W-1:0]         cmd,
    input  logic [sle_pkg::POS_W-1:0]         position,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic                              ok,
    output logic signed [sle_pkg::DATA_W-1:0] read_value,
    output logic [sle_pkg::LEN_W-1:0]         found_position,
    output logic [sle_pkg::LEN_W-1:0]         list_length,
    output logic                              is_empty
);
    import sle_pkg::*;

    ctl_t    ctl;
    status_t status;

    // Sequence each request: capture, execute or scan, then raise done.
    sle_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    // Hold the cells, the length and the registered result.
    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .ctl            (ctl),
        .status         (status),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty)
    );

`ifndef SYNTHESIS
    // Done always lands back in the idle state, ready for the next request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted request makes the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A locate hit is only reported on a successful result with a zero read_value.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (found_position != '0)) |-> (ok && (read_value == '0)))
        else $error("found position reported on a failed or read result");

    // Done is a single-cycle strobe per request.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule
